// File: src/stcd_pkg.sv
// package for the seconds to calendar date unit: types, constants and month table
`default_nettype none
package stcd_pkg;

    localparam int DATA_W          = 32;
    localparam int YEAR_W          = 7;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;
    localparam int HOUR_W          = 5;
    localparam int MINUTE_W        = 6;
    localparam int SECOND_W        = 6;
    localparam int DEF_YEAR_SPAN   = 100;
    localparam int MONTHS_PER_YEAR = 12;
    localparam int OUT_DATA_W      = 40;

    localparam logic [DATA_W-1:0] SECS_PER_MIN  = 32'd60;
    localparam logic [DATA_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [DATA_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [DATA_W-1:0] SECS_LEAP_YR  = 32'd31622400;
    localparam logic [DATA_W-1:0] SECS_NORM_YR  = 32'd31536000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year_offset;
        logic [MONTH_W-1:0]  month_number;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic [SECOND_W-1:0] second_of_minute;
        logic                out_of_range;
    } result_t;

    function automatic logic [DATA_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] days;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   days = 5'd30;
            4'd1:                                      days = leap ? 5'd29 : 5'd28;
            default:                                   days = 5'd31;
        endcase
        return DATA_W'(days) * SECS_PER_DAY;
    endfunction

endpackage
`default_nettype wire

// File: src/stcd_sub.sv
// shared compare and subtract unit
`default_nettype none
module stcd_sub (
    input  wire logic [stcd_pkg::DATA_W-1:0] a,
    input  wire logic [stcd_pkg::DATA_W-1:0] b,
    output logic                             ge,
    output logic [stcd_pkg::DATA_W-1:0]      diff
);
    import stcd_pkg::*;

    logic [DATA_W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[DATA_W];
    assign diff = wide[DATA_W-1:0];

endmodule
`default_nettype wire

// File: src/stcd_engine.sv
// sequencer that walks years, months and restoring division steps over the shared subtractor
`default_nettype none
module stcd_engine #(
    parameter int YEAR_SPAN = stcd_pkg::DEF_YEAR_SPAN
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [stcd_pkg::DATA_W-1:0] seconds_count,
    input  wire logic                        take,
    output logic                             idle,
    output logic                             done,
    output stcd_pkg::result_t                res
);
    import stcd_pkg::*;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   rest_reg, rest_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [SECOND_W-1:0] quo_reg, quo_next;
    logic [2:0]          bit_reg, bit_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MINUTE_W-1:0] min_reg, min_next;
    logic [SECOND_W-1:0] sec_reg, sec_next;
    logic                oor_reg, oor_next;

    logic [DATA_W-1:0]   sub_b;
    logic [DATA_W-1:0]   sub_diff;
    logic                sub_ge;
    logic                leap;
    logic [SECOND_W-1:0] quo_shift;
    logic [DATA_W-1:0]   rest_step;

    stcd_sub u_sub (
        .a    (rest_reg),
        .b    (sub_b),
        .ge   (sub_ge),
        .diff (sub_diff)
    );

    assign leap      = (year_reg[1:0] == 2'b00);
    assign quo_shift = {quo_reg[SECOND_W-2:0], sub_ge};
    assign rest_step = sub_ge ? sub_diff : rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg  <= rest_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        quo_reg   <= quo_next;
        bit_reg   <= bit_next;
        day_reg   <= day_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        oor_reg   <= oor_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rest_next  = rest_reg;
        year_next  = year_reg;
        month_next = month_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        oor_next   = oor_reg;
        sub_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rest_next  = seconds_count;
                    year_next  = '0;
                    oor_next   = 1'b0;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                sub_b = leap ? SECS_LEAP_YR : SECS_NORM_YR;
                if (sub_ge)
                begin
                    rest_next = sub_diff;
                    if (year_reg == YEAR_W'(YEAR_SPAN - 1))
                    begin
                        oor_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        year_next = year_reg + 1'b1;
                    end
                end
                else
                begin
                    month_next = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                sub_b = month_secs(month_reg, leap);
                if (sub_ge && (month_reg != MONTH_W'(MONTHS_PER_YEAR - 1)))
                begin
                    rest_next  = sub_diff;
                    month_next = month_reg + 1'b1;
                end
                else
                begin
                    quo_next   = '0;
                    bit_next   = 3'd4;
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                sub_b     = SECS_PER_DAY << bit_reg;
                rest_next = rest_step;
                quo_next  = quo_shift;
                bit_next  = bit_reg - 1'b1;
                if (bit_reg == 3'd0)
                begin
                    day_next   = quo_shift[DAY_W-1:0];
                    quo_next   = '0;
                    bit_next   = 3'd4;
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                sub_b     = SECS_PER_HOUR << bit_reg;
                rest_next = rest_step;
                quo_next  = quo_shift;
                bit_next  = bit_reg - 1'b1;
                if (bit_reg == 3'd0)
                begin
                    hour_next  = quo_shift[HOUR_W-1:0];
                    quo_next   = '0;
                    bit_next   = 3'd5;
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                sub_b     = SECS_PER_MIN << bit_reg;
                rest_next = rest_step;
                quo_next  = quo_shift;
                bit_next  = bit_reg - 1'b1;
                if (bit_reg == 3'd0)
                begin
                    min_next   = quo_shift;
                    sec_next   = rest_step[SECOND_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        if (oor_reg)
        begin
            res              = '0;
            res.out_of_range = 1'b1;
        end
        else
        begin
            res.year_offset      = year_reg;
            res.month_number     = month_reg + 1'b1;
            res.day_of_month     = day_reg + 1'b1;
            res.hour_of_day      = hour_reg;
            res.minute_of_hour   = min_reg;
            res.second_of_minute = sec_reg;
            res.out_of_range     = 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: src/seconds_to_calendar_date_unit.sv
// top level of the seconds to calendar date unit with stream ports and output register
// Converts a 32-bit count of seconds since the start of epoch year 0 into year offset,
// month, day, hour, minute and second, or raises out_of_range once YEAR_SPAN whole years
// fit in the count. One beat is converted at a time by a sequencer over a single 32-bit
// compare and subtract unit: it takes off whole years one by one, then whole months one
// by one, then runs 16 restoring division steps for day, hour and minute. The finished
// result waits in the engine until the output register is free, and only then is the
// next beat accepted.
// The input is ready again once the result has moved into the output register, so the
// next count can start converting while a result waits on the output side.
`default_nettype none
module seconds_to_calendar_date_unit #(
    parameter int YEAR_SPAN = stcd_pkg::DEF_YEAR_SPAN
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // seconds_count
    input  wire logic [stcd_pkg::DATA_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // year_offset, month_number, day_of_month, hour_of_day, minute_of_hour,
    // second_of_minute, zero fill
    output logic [stcd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // out_of_range
    output logic                                 m_axis_tuser
);
    import stcd_pkg::*;

    logic    eng_idle;
    logic    eng_done;
    logic    take;
    result_t eng_res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    assign take = eng_done && (!out_valid_reg || m_axis_tready);

    stcd_engine #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (s_axis_tvalid),
        .seconds_count (s_axis_tdata),
        .take          (take),
        .idle          (eng_idle),
        .done          (eng_done),
        .res           (eng_res)
    );

    assign s_axis_tready = eng_idle;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= eng_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.out_of_range;
    assign m_axis_tdata  = {7'd0,
                            out_reg.second_of_minute,
                            out_reg.minute_of_hour,
                            out_reg.hour_of_day,
                            out_reg.day_of_month,
                            out_reg.month_number,
                            out_reg.year_offset};

    // busy after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accepting a beat");

    // out of range beat carries an all-zero date
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out of range beat with nonzero date");

    // date fields stay in their ranges
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            out_reg.month_number >= 4'd1 && out_reg.month_number <= 4'd12 &&
            out_reg.day_of_month != 5'd0 &&
            out_reg.year_offset < YEAR_W'(YEAR_SPAN))
        else $error("date field out of range");

    // time fields stay in their ranges
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            out_reg.hour_of_day < 5'd24 && out_reg.minute_of_hour < 6'd60 &&
            out_reg.second_of_minute < 6'd60)
        else $error("time field out of range");

endmodule
`default_nettype wire
